FILE: hw/rtl/rcdq_pkg.sv
`timescale 1ns / 1ps
// Package for the restricted circular deque: field widths, command,
// status, mode and register index codes. No dependencies.

package rcdq_pkg;

  localparam int DATA_W     = 32;
  localparam int CAP_W      = 5;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_DENIED = 2'd3;

  localparam logic [MODE_W-1:0] MODE_INPUT_RESTR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OUTPUT_RESTR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd1;

endpackage

FILE: hw/rtl/rcdq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the deque: command, response and
// configuration write. Depends on rcdq_pkg.

interface rcdq_req_if;
  logic                               valid;
  logic                               ready;
  logic [rcdq_pkg::CMD_W-1:0]         cmd;
  logic signed [rcdq_pkg::DATA_W-1:0] push_value;

  modport source (output valid, cmd, push_value, input ready);
  modport sink (input valid, cmd, push_value, output ready);
endinterface

interface rcdq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [rcdq_pkg::STATUS_W-1:0]      status;
  logic signed [rcdq_pkg::DATA_W-1:0] popped_value;
  logic [rcdq_pkg::CAP_W-1:0]         occupancy;

  modport source (output valid, status, popped_value, occupancy, input ready);
  modport sink (input valid, status, popped_value, occupancy, output ready);
endinterface

interface rcdq_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rcdq_pkg::CFG_IDX_W-1:0]    index;
  logic [rcdq_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/restricted_circular_deque.sv
`timescale 1ns / 1ps
// Restricted circular deque of 32-bit signed values held in one RAM.
// Depends on rcdq_pkg and the channel interfaces in rcdq_if.
//
// Commands arrive on req (push rear, push front, pop front, pop rear) and
// each produces exactly one response on rsp with a status, the popped value
// and the occupancy after the command. Register 0 of cfg sets the capacity,
// the wrap point of both ring indices; it is ignored unless the deque is
// empty. Register 1 sets the restriction mode.
// A command is decided in the cycle of its transfer; indices, count and the
// RAM write are updated then. A pop reads the RAM through a registered port.
// The response passes through the holding state for pushes and rejected
// commands, and through the read state and then the holding state for a
// successful pop; req is not ready again until the holding state is left.
// The response sits in an output register, so the next command is accepted
// while it waits. When rsp is stalled, a finished result waits in a holding
// stage and req stays low until the output register frees up.
// Reset empties the deque, sets the capacity to 16 (or MAX_SLOTS if that is
// smaller) and the mode to unrestricted. The RAM contents are not cleared.

module restricted_circular_deque #(
  parameter int MAX_SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  rcdq_req_if.sink     req,
  rcdq_rsp_if.source   rsp,
  rcdq_cfg_if.sink     cfg
);

  localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CMP_W   = (IDX_W + 1 > rcdq_pkg::CAP_W) ? IDX_W + 1 : rcdq_pkg::CAP_W;
  localparam int CAP_MAX = (MAX_SLOTS < 31) ? MAX_SLOTS : 31;
  localparam int CAP_RST = (MAX_SLOTS < 16) ? MAX_SLOTS : 16;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [rcdq_pkg::DATA_W-1:0] mem [MAX_SLOTS];
  logic signed [rcdq_pkg::DATA_W-1:0] rd_data;

  logic [IDX_W-1:0]              head;
  logic [IDX_W-1:0]              tail;
  logic [rcdq_pkg::CAP_W-1:0]    count;
  logic [rcdq_pkg::CAP_W-1:0]    capacity;
  logic [rcdq_pkg::MODE_W-1:0]   restrict_mode;

  logic [IDX_W-1:0]              head_next;
  logic [IDX_W-1:0]              tail_next;
  logic [rcdq_pkg::CAP_W-1:0]    count_next;
  logic [rcdq_pkg::STATUS_W-1:0] status_next;

  logic [rcdq_pkg::STATUS_W-1:0]      pend_status;
  logic [rcdq_pkg::CAP_W-1:0]         pend_occ;
  logic signed [rcdq_pkg::DATA_W-1:0] pend_popped;

  logic                               rsp_valid;
  logic [rcdq_pkg::STATUS_W-1:0]      rsp_status;
  logic [rcdq_pkg::CAP_W-1:0]         rsp_occ;
  logic signed [rcdq_pkg::DATA_W-1:0] rsp_popped;

  logic             accept;
  logic             wr_en;
  logic             rd_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             forbid;
  logic             is_push;
  logic             full;
  logic             empty;
  logic [IDX_W-1:0] cap_m1;
  logic [IDX_W-1:0] head_up;
  logic [IDX_W-1:0] head_dn;
  logic [IDX_W-1:0] tail_up;
  logic [IDX_W-1:0] tail_dn;
  logic             out_free;

  logic [rcdq_pkg::CAP_W-1:0] cfg_cap;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign out_free = !rsp_valid || rsp.ready;

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.popped_value = rsp_popped;
  assign rsp.occupancy    = rsp_occ;

  always_comb begin
    if (cfg.data == '0) begin
      cfg_cap = rcdq_pkg::CAP_W'(1);
    end else if (CMP_W'(cfg.data) > CMP_W'(CAP_MAX)) begin
      cfg_cap = rcdq_pkg::CAP_W'(CAP_MAX);
    end else begin
      cfg_cap = cfg.data;
    end
  end

  always_comb begin
    cap_m1  = IDX_W'(capacity - rcdq_pkg::CAP_W'(1));
    head_up = (CMP_W'(head) + CMP_W'(1) >= CMP_W'(capacity)) ? '0 : IDX_W'(head + IDX_W'(1));
    tail_up = (CMP_W'(tail) + CMP_W'(1) >= CMP_W'(capacity)) ? '0 : IDX_W'(tail + IDX_W'(1));
    head_dn = (head == '0 || CMP_W'(head) >= CMP_W'(capacity)) ? cap_m1
                                                              : IDX_W'(head - IDX_W'(1));
    tail_dn = (tail == '0 || CMP_W'(tail) >= CMP_W'(capacity)) ? cap_m1
                                                              : IDX_W'(tail - IDX_W'(1));
    forbid  = (req.cmd == rcdq_pkg::CMD_PUSH_FRONT &&
               restrict_mode == rcdq_pkg::MODE_INPUT_RESTR) ||
              (req.cmd == rcdq_pkg::CMD_POP_REAR &&
               restrict_mode == rcdq_pkg::MODE_OUTPUT_RESTR);
    is_push = (req.cmd == rcdq_pkg::CMD_PUSH_REAR) || (req.cmd == rcdq_pkg::CMD_PUSH_FRONT);
    full    = (count >= capacity);
    empty   = (count == '0);
  end

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    status_next = rcdq_pkg::STATUS_DONE;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = tail_up;
    rd_addr     = head;
    if (forbid) begin
      status_next = rcdq_pkg::STATUS_DENIED;
    end else if (is_push) begin
      if (full) begin
        status_next = rcdq_pkg::STATUS_FULL;
      end else if (req.cmd == rcdq_pkg::CMD_PUSH_REAR) begin
        wr_en      = accept;
        wr_addr    = tail_up;
        tail_next  = tail_up;
        count_next = count + rcdq_pkg::CAP_W'(1);
      end else begin
        wr_en      = accept;
        wr_addr    = head_dn;
        head_next  = head_dn;
        count_next = count + rcdq_pkg::CAP_W'(1);
      end
    end else begin
      if (empty) begin
        status_next = rcdq_pkg::STATUS_EMPTY;
      end else if (req.cmd == rcdq_pkg::CMD_POP_FRONT) begin
        rd_en      = accept;
        rd_addr    = head;
        head_next  = head_up;
        count_next = count - rcdq_pkg::CAP_W'(1);
      end else begin
        rd_en      = accept;
        rd_addr    = tail;
        tail_next  = tail_dn;
        count_next = count - rcdq_pkg::CAP_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = rd_en ? ST_READ : ST_HOLD;
        end
      end
      ST_READ: begin
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req.push_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      capacity      <= rcdq_pkg::CAP_W'(CAP_RST);
      restrict_mode <= '0;
      head          <= '0;
      tail          <= IDX_W'(CAP_RST - 1);
      count         <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.index == rcdq_pkg::REG_CAPACITY && count == '0) begin
        capacity <= cfg_cap;
        head     <= '0;
        tail     <= IDX_W'(cfg_cap - rcdq_pkg::CAP_W'(1));
      end else if (accept) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
      if (cfg.valid && cfg.index == rcdq_pkg::REG_MODE) begin
        restrict_mode <= cfg.data[rcdq_pkg::MODE_W-1:0];
      end
      if (state == ST_HOLD && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_next;
      pend_occ    <= count_next;
      pend_popped <= '0;
    end else if (state == ST_READ) begin
      pend_popped <= rd_data;
    end
    if (state == ST_HOLD && out_free) begin
      rsp_status <= pend_status;
      rsp_occ    <= pend_occ;
      rsp_popped <= pend_popped;
    end
  end

endmodule

FILE: hw/rtl/rcdq_check.sv
`timescale 1ns / 1ps
// Port-level checker for the restricted circular deque, bound to the deque
// module itself. Depends on rcdq_pkg.

module rcdq_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [rcdq_pkg::STATUS_W-1:0]      rsp_status,
  input logic signed [rcdq_pkg::DATA_W-1:0] rsp_popped_value,
  input logic [rcdq_pkg::CAP_W-1:0]         rsp_occupancy
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second command taken while one is in flight");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == rcdq_pkg::STATUS_EMPTY |-> rsp_occupancy == '0)
    else $error("empty status with entries held");

  a_popped_only_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_popped_value != '0 |-> rsp_status == rcdq_pkg::STATUS_DONE)
    else $error("nonzero popped value on a rejected command");

endmodule

bind restricted_circular_deque rcdq_check u_rcdq_check (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_popped_value (rsp.popped_value),
  .rsp_occupancy    (rsp.occupancy)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for restricted_circular_deque: a directed table,
// then random command phases, checked by a bench deque model or typed rows.
// Depends on rcdq_pkg, the channel interfaces in rcdq_if and the deque RTL.

module tb_top;

  localparam int SLOTS        = 16;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_LIMIT  = 5000;

  localparam logic [rcdq_pkg::MODE_W-1:0] MODE_OPEN      = 2'd0;
  localparam logic [rcdq_pkg::MODE_W-1:0] MODE_OPEN_ALT  = 2'd3;
  localparam logic [rcdq_pkg::CFG_IDX_W-1:0] REG_NONE_LO = 2'd2;
  localparam logic [rcdq_pkg::CFG_IDX_W-1:0] REG_NONE_HI = 2'd3;

  typedef logic signed [rcdq_pkg::DATA_W-1:0] word_t;
  typedef logic [rcdq_pkg::CMD_W-1:0]         cmd_t;
  typedef logic [rcdq_pkg::STATUS_W-1:0]      status_t;
  typedef logic [rcdq_pkg::CAP_W-1:0]         occ_t;
  typedef logic [rcdq_pkg::CFG_IDX_W-1:0]     reg_idx_t;
  typedef logic [rcdq_pkg::CFG_DATA_W-1:0]    reg_data_t;

  typedef struct packed {
    status_t status;
    word_t   popped;
    occ_t    occupancy;
  } outcome_t;

  typedef enum logic [1:0] {ROW_OPEN, ROW_TYPED, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    cmd_t      cmd;
    word_t     value;
    reg_idx_t  index;
    reg_data_t data;
    outcome_t  result;
  } plan_row_t;

  logic clk;
  logic rst;

  rcdq_req_if req ();
  rcdq_rsp_if rsp ();
  rcdq_cfg_if cfg ();

  restricted_circular_deque dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  word_t                       mirror_slots [SLOTS];
  int unsigned                 mirror_head  = 0;
  int unsigned                 mirror_tail  = SLOTS - 1;
  int unsigned                 mirror_count = 0;
  int unsigned                 mirror_cap   = SLOTS;
  logic [rcdq_pkg::MODE_W-1:0] mirror_mode  = MODE_OPEN;

  outcome_t    awaited [$];
  logic        typed_valid;
  outcome_t    typed_result;
  int unsigned rsp_hold     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches   = 0;
  int unsigned issued       = 0;
  bit          steady       = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int unsigned pause_length();
    return steady ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic int unsigned ring_up(int unsigned idx);
    return (idx + 1 >= mirror_cap) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned ring_down(int unsigned idx);
    return (idx == 0 || idx >= mirror_cap) ? mirror_cap - 1 : idx - 1;
  endfunction

  function automatic outcome_t deque_outcome(cmd_t op, word_t value);
    outcome_t r;
    r.status = rcdq_pkg::STATUS_DONE;
    r.popped = '0;
    if ((op == rcdq_pkg::CMD_PUSH_FRONT && mirror_mode == rcdq_pkg::MODE_INPUT_RESTR) ||
        (op == rcdq_pkg::CMD_POP_REAR && mirror_mode == rcdq_pkg::MODE_OUTPUT_RESTR)) begin
      r.status = rcdq_pkg::STATUS_DENIED;
    end else if (op == rcdq_pkg::CMD_PUSH_REAR || op == rcdq_pkg::CMD_PUSH_FRONT) begin
      if (mirror_count >= mirror_cap) begin
        r.status = rcdq_pkg::STATUS_FULL;
      end else if (op == rcdq_pkg::CMD_PUSH_REAR) begin
        mirror_tail = ring_up(mirror_tail);
        mirror_slots[mirror_tail] = value;
        mirror_count++;
      end else begin
        mirror_head = ring_down(mirror_head);
        mirror_slots[mirror_head] = value;
        mirror_count++;
      end
    end else if (mirror_count == 0) begin
      r.status = rcdq_pkg::STATUS_EMPTY;
    end else if (op == rcdq_pkg::CMD_POP_FRONT) begin
      r.popped = mirror_slots[mirror_head];
      mirror_head = ring_up(mirror_head);
      mirror_count--;
    end else begin
      r.popped = mirror_slots[mirror_tail];
      mirror_tail = ring_down(mirror_tail);
      mirror_count--;
    end
    r.occupancy = mirror_count[rcdq_pkg::CAP_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t open_row(cmd_t op, word_t value);
    plan_row_t r;
    r.kind = ROW_OPEN;
    r.cmd = op;
    r.value = value;
    r.index = rcdq_pkg::REG_CAPACITY;
    r.data = '0;
    r.result = '0;
    return r;
  endfunction

  function automatic plan_row_t typed_row(cmd_t op, word_t value, status_t status,
                                          word_t popped, occ_t occupancy);
    plan_row_t r;
    r = open_row(op, value);
    r.kind = ROW_TYPED;
    r.result = '{status, popped, occupancy};
    return r;
  endfunction

  function automatic plan_row_t reg_row(reg_idx_t idx, reg_data_t data);
    plan_row_t r;
    r = open_row(rcdq_pkg::CMD_PUSH_REAR, '0);
    r.kind = ROW_REG;
    r.index = idx;
    r.data = data;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rsp.valid && rsp.ready) begin
      rsp_hold = pause_length();
    end else if (rsp_hold != 0) begin
      rsp_hold--;
    end
    rsp.ready <= (rsp_hold == 0);
  end

  always @(posedge clk) begin : monitor
    outcome_t want;
    outcome_t got;
    if (!rst) begin
      quiet_cycles++;
      if (cfg.valid && cfg.ready) begin
        quiet_cycles = 0;
        if (cfg.index == rcdq_pkg::REG_CAPACITY) begin
          if (mirror_count == 0) begin
            mirror_cap = (cfg.data == 0) ? 1 : (cfg.data > SLOTS) ? SLOTS : cfg.data;
            mirror_head = 0;
            mirror_tail = mirror_cap - 1;
          end
        end else if (cfg.index == rcdq_pkg::REG_MODE) begin
          mirror_mode = cfg.data[rcdq_pkg::MODE_W-1:0];
        end
      end
      if (req.valid && req.ready) begin
        quiet_cycles = 0;
        want = deque_outcome(req.cmd, req.push_value);
        awaited.push_back(typed_valid ? typed_result : want);
      end
      if (rsp.valid && rsp.ready) begin
        quiet_cycles = 0;
        got = '{rsp.status, rsp.popped_value, rsp.occupancy};
        if (awaited.size() == 0) begin
          $display("%0t: unexpected response: status %0d value %0d occupancy %0d",
                   $time, got.status, got.popped, got.occupancy);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d (status/value/occupancy)",
                     $time, want.status, want.popped, want.occupancy,
                     got.status, got.popped, got.occupancy);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic send_command(cmd_t op, word_t value, bit typed, outcome_t result);
    int unsigned gap;
    gap = pause_length();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= op;
    req.push_value <= value;
    typed_valid <= typed;
    typed_result <= result;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    issued++;
  endtask

  task automatic write_register(reg_idx_t idx, reg_data_t data);
    int unsigned gap;
    gap = pause_length();
    if (gap != 0) begin
      cfg.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // Drops both request channels and waits until every response is back.
  task automatic settle();
    req.valid <= 1'b0;
    cfg.valid <= 1'b0;
    do @(negedge clk); while (awaited.size() != 0);
    @(posedge clk);
  endtask

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("restricted_circular_deque: mismatch");
    $finish;
  end

  initial begin : stimulus
    plan_row_t   plan [$];
    outcome_t    none;
    int unsigned first_random;
    int unsigned drain;
    int unsigned bias;
    int unsigned n;
    cmd_t        op;
    word_t       value;
    none = '0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.cmd = rcdq_pkg::CMD_PUSH_REAR;
    req.push_value = '0;
    cfg.valid = 1'b0;
    cfg.index = rcdq_pkg::REG_CAPACITY;
    cfg.data = '0;
    typed_valid = 1'b0;
    typed_result = '0;

    plan.push_back(typed_row(rcdq_pkg::CMD_POP_FRONT, 32'sd0,
                             rcdq_pkg::STATUS_EMPTY, 32'sd0, 5'd0));
    plan.push_back(typed_row(rcdq_pkg::CMD_POP_REAR, -32'sd1,
                             rcdq_pkg::STATUS_EMPTY, 32'sd0, 5'd0));
    plan.push_back(typed_row(rcdq_pkg::CMD_PUSH_REAR, 32'sh7FFFFFFF,
                             rcdq_pkg::STATUS_DONE, 32'sd0, 5'd1));
    plan.push_back(typed_row(rcdq_pkg::CMD_PUSH_FRONT, 32'sh80000000,
                             rcdq_pkg::STATUS_DONE, 32'sd0, 5'd2));
    plan.push_back(open_row(rcdq_pkg::CMD_PUSH_REAR, 32'sd0));
    plan.push_back(open_row(rcdq_pkg::CMD_PUSH_FRONT, -32'sd1));
    plan.push_back(open_row(rcdq_pkg::CMD_POP_REAR, 32'sd0));
    plan.push_back(typed_row(rcdq_pkg::CMD_POP_REAR, 32'sd0,
                             rcdq_pkg::STATUS_DONE, 32'sh7FFFFFFF, 5'd2));
    plan.push_back(open_row(rcdq_pkg::CMD_POP_FRONT, 32'sd0));
    plan.push_back(typed_row(rcdq_pkg::CMD_POP_FRONT, 32'sd0,
                             rcdq_pkg::STATUS_DONE, 32'sh80000000, 5'd0));
    plan.push_back(reg_row(rcdq_pkg::REG_CAPACITY, 5'd0));
    plan.push_back(open_row(rcdq_pkg::CMD_PUSH_REAR, 32'sd5));
    plan.push_back(typed_row(rcdq_pkg::CMD_PUSH_FRONT, 32'sd6,
                             rcdq_pkg::STATUS_FULL, 32'sd0, 5'd1));
    plan.push_back(typed_row(rcdq_pkg::CMD_PUSH_REAR, 32'sd7,
                             rcdq_pkg::STATUS_FULL, 32'sd0, 5'd1));
    plan.push_back(reg_row(rcdq_pkg::REG_CAPACITY, 5'd9));
    plan.push_back(open_row(rcdq_pkg::CMD_POP_REAR, 32'sd0));
    plan.push_back(typed_row(rcdq_pkg::CMD_POP_FRONT, 32'sd0,
                             rcdq_pkg::STATUS_EMPTY, 32'sd0, 5'd0));
    plan.push_back(reg_row(rcdq_pkg::REG_CAPACITY, 5'd31));
    plan.push_back(reg_row(rcdq_pkg::REG_MODE,
                           rcdq_pkg::CFG_DATA_W'(rcdq_pkg::MODE_INPUT_RESTR)));
    plan.push_back(typed_row(rcdq_pkg::CMD_PUSH_FRONT, 32'sd3,
                             rcdq_pkg::STATUS_DENIED, 32'sd0, 5'd0));
    plan.push_back(open_row(rcdq_pkg::CMD_PUSH_REAR, 32'shA5A5A5A5));
    plan.push_back(open_row(rcdq_pkg::CMD_POP_REAR, 32'sd0));
    plan.push_back(reg_row(rcdq_pkg::REG_MODE,
                           rcdq_pkg::CFG_DATA_W'(rcdq_pkg::MODE_OUTPUT_RESTR)));
    plan.push_back(open_row(rcdq_pkg::CMD_PUSH_FRONT, 32'sd2));
    plan.push_back(typed_row(rcdq_pkg::CMD_POP_REAR, 32'sd0,
                             rcdq_pkg::STATUS_DENIED, 32'sd0, 5'd1));
    plan.push_back(open_row(rcdq_pkg::CMD_POP_FRONT, 32'sd0));
    plan.push_back(reg_row(rcdq_pkg::REG_MODE, rcdq_pkg::CFG_DATA_W'(MODE_OPEN_ALT)));
    plan.push_back(open_row(rcdq_pkg::CMD_PUSH_FRONT, 32'sh5A5A5A5A));
    plan.push_back(open_row(rcdq_pkg::CMD_POP_REAR, 32'sd0));
    plan.push_back(reg_row(REG_NONE_LO, 5'd31));
    plan.push_back(reg_row(REG_NONE_HI, 5'd0));
    plan.push_back(reg_row(rcdq_pkg::REG_MODE, rcdq_pkg::CFG_DATA_W'(MODE_OPEN)));
    plan.push_back(typed_row(rcdq_pkg::CMD_POP_FRONT, 32'sd0,
                             rcdq_pkg::STATUS_EMPTY, 32'sd0, 5'd0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_register(plan[i].index, plan[i].data);
        settle();
      end else begin
        send_command(plan[i].cmd, plan[i].value, plan[i].kind == ROW_TYPED,
                     plan[i].result);
      end
    end

    first_random = issued;
    while (issued < first_random + RANDOM_ITEMS) begin
      settle();
      drain = ($urandom_range(0, 2) != 0) ? mirror_count : 0;
      repeat (drain) send_command(rcdq_pkg::CMD_POP_FRONT, $urandom, 1'b0, none);
      settle();
      case ($urandom_range(0, 5))
        0: write_register(rcdq_pkg::REG_CAPACITY, 5'd1);
        1: write_register(rcdq_pkg::REG_CAPACITY, 5'd16);
        2: write_register(rcdq_pkg::REG_CAPACITY, 5'd0);
        3: write_register(rcdq_pkg::REG_CAPACITY,
                          rcdq_pkg::CFG_DATA_W'($urandom_range(17, 31)));
        default: write_register(rcdq_pkg::REG_CAPACITY,
                                rcdq_pkg::CFG_DATA_W'($urandom_range(2, 15)));
      endcase
      write_register(rcdq_pkg::REG_MODE, rcdq_pkg::CFG_DATA_W'($urandom));
      if ($urandom_range(0, 7) == 0) begin
        write_register($urandom_range(0, 1) ? REG_NONE_HI : REG_NONE_LO,
                       rcdq_pkg::CFG_DATA_W'($urandom));
      end
      settle();
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: bias = 20;
        1: bias = 50;
        2: bias = 80;
        default: bias = 95;
      endcase
      n = $urandom_range(20, 80);
      repeat (n) begin
        if ($urandom_range(1, 100) <= bias) begin
          op = $urandom_range(0, 1) ? rcdq_pkg::CMD_PUSH_FRONT : rcdq_pkg::CMD_PUSH_REAR;
        end else begin
          op = $urandom_range(0, 1) ? rcdq_pkg::CMD_POP_REAR : rcdq_pkg::CMD_POP_FRONT;
        end
        case ($urandom_range(0, 9))
          0: value = 32'sh7FFFFFFF;
          1: value = 32'sh80000000;
          2: value = 32'sd0;
          3: value = -32'sd1;
          default: value = $urandom;
        endcase
        send_command(op, value, 1'b0, none);
      end
      steady = 1'b0;
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("restricted_circular_deque: match");
    end else begin
      $display("restricted_circular_deque: mismatch");
    end
    $finish;
  end

endmodule
